// File: hdl/rps_pkg.sv
// Package for the rumble pattern sequencer.
// Holds the command, activity, status and drive codes and the wind-down length.
// No dependencies; used by rumble_pattern_sequencer_unit.
package rps_pkg;

    localparam int NUM_DRIVES = 4;

    localparam logic [15:0] WIND_DOWN = 16'd3;

    typedef enum logic [2:0] {
        CMD_TICK   = 3'd0,
        CMD_RESET  = 3'd1,
        CMD_START  = 3'd2,
        CMD_STOP   = 3'd3,
        CMD_REPEAT = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ACT_IDLE     = 2'd0,
        ACT_STOPPING = 2'd1,
        ACT_STARTING = 2'd2,
        ACT_OSC      = 2'd3
    } activity_t;

    typedef enum logic [1:0] {
        DRV_NONE  = 2'd0,
        DRV_STOP  = 2'd1,
        DRV_START = 2'd2
    } drive_t;

    localparam logic [1:0] ST_ABSENT = 2'd0;
    localparam logic [1:0] ST_OFF    = 2'd1;
    localparam logic [1:0] ST_ON     = 2'd2;

    // Register indexes on the configuration port.
    localparam logic REG_ENABLED = 1'b0;

endpackage

// File: hdl/rumble_pattern_sequencer_unit.sv
// Top level of the rumble pattern sequencer: per-channel motor sequencing.
// Depends on rps_pkg for command, activity, status and drive codes.
//
//  Channel   Handshake              Payload
//  -------   --------------------   ----------------------------------------------
//  input     in_valid / in_stall    command, channel, pak_present, on_time,
//                                   off_time, run_length
//  result    out_valid / out_stall  drive_0, drive_1, drive_2, drive_3
//  config    psel/penable/pwrite    paddr, pwdata, prdata, pready (always high)
//
// Every command is held in the input register and moves on into the result
// register when that side is free, so one transfer can be accepted every cycle
// while the result side does not stall. The channel state is updated in the same
// cycle as the result is computed, so the following command always sees it. A
// stall on the result side holds the input register, which in turn raises
// in_stall. Reset clears all channel state and sets enabled.
module rumble_pattern_sequencer_unit #(
    parameter int CHANNELS = 4
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  command,
    input  logic [1:0]  channel,
    input  logic        pak_present,
    input  logic [14:0] on_time,
    input  logic [14:0] off_time,
    input  logic [14:0] run_length,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  drive_0,
    output logic [1:0]  drive_1,
    output logic [1:0]  drive_2,
    output logic [1:0]  drive_3,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ------------------------------------------------------------------
    // Configuration register. Only bit 0 of the data matters; the word
    // address sits in paddr[2], the low two bits being the byte offset.
    // ------------------------------------------------------------------
    logic enabled_reg;
    logic cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == rps_pkg::REG_ENABLED);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            enabled_reg <= pwdata[0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == rps_pkg::REG_ENABLED && paddr[1:0] == 2'b00)
        begin
            prdata = {31'd0, enabled_reg};
        end
    end

    // ------------------------------------------------------------------
    // Input register and handshake.
    // ------------------------------------------------------------------
    logic        item_valid_reg;
    logic        item_valid_next;
    logic [2:0]  cmd_reg;
    logic [1:0]  chan_reg;
    logic        pak_reg;
    logic [14:0] on_reg;
    logic [14:0] off_reg;
    logic [14:0] run_reg;
    logic        in_take;
    logic        advance;
    logic        out_valid_reg;
    logic        out_valid_next;

    // The item in the input register moves on when the result register is
    // empty or its contents are being taken in this cycle.
    assign advance  = item_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = item_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (in_take)
        begin
            item_valid_next = 1'b1;
        end
        else if (advance)
        begin
            item_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg  <= command;
            chan_reg <= channel;
            pak_reg  <= pak_present;
            on_reg   <= on_time;
            off_reg  <= off_time;
            run_reg  <= run_length;
        end
    end

    // ------------------------------------------------------------------
    // Per-channel state and its update. All channels are worked on in
    // parallel; a tick advances every one of them, the other commands
    // touch only the addressed channel.
    // ------------------------------------------------------------------
    rps_pkg::drive_t chan_drive [CHANNELS];

    genvar c;
    generate
        for (c = 0; c < CHANNELS; c++)
        begin : g_chan
            logic [1:0]          status_reg;
            logic [1:0]          status_next;
            rps_pkg::activity_t  activity_reg;
            rps_pkg::activity_t  activity_next;
            logic [15:0]         timer_reg;
            logic [15:0]         timer_next;
            logic [15:0]         remaining_reg;
            logic [15:0]         remaining_next;
            logic [14:0]         on_period_reg;
            logic [14:0]         on_period_next;
            logic [14:0]         off_period_reg;
            logic [14:0]         off_period_next;
            rps_pkg::drive_t     drive;
            logic                selected;
            logic [15:0]         rem_dec;
            logic [15:0]         timer_load;

            assign selected = (int'(chan_reg) == c);
            assign rem_dec  = remaining_reg - 16'd1;

            always_comb
            begin
                status_next     = status_reg;
                activity_next   = activity_reg;
                timer_next      = timer_reg;
                remaining_next  = remaining_reg;
                on_period_next  = on_period_reg;
                off_period_next = off_period_reg;
                drive           = rps_pkg::DRV_NONE;
                timer_load      = timer_reg;

                unique case (cmd_reg)
                    rps_pkg::CMD_TICK:
                    begin
                        if (enabled_reg)
                        begin
                            unique case (activity_reg)
                                rps_pkg::ACT_STOPPING:
                                begin
                                    remaining_next = rem_dec;
                                    if (rem_dec == 16'd0)
                                    begin
                                        status_next   = rps_pkg::ST_OFF;
                                        activity_next = rps_pkg::ACT_IDLE;
                                    end
                                    drive = rps_pkg::DRV_STOP;
                                end
                                rps_pkg::ACT_STARTING:
                                begin
                                    drive         = rps_pkg::DRV_START;
                                    status_next   = rps_pkg::ST_ON;
                                    activity_next = rps_pkg::ACT_IDLE;
                                end
                                rps_pkg::ACT_OSC:
                                begin
                                    // A phase ends when the timer has run down to zero
                                    // or below; the motor then flips if the next
                                    // period is not empty.
                                    if (timer_reg == 16'd0 || timer_reg[15])
                                    begin
                                        if (status_reg == rps_pkg::ST_OFF)
                                        begin
                                            if (on_period_reg != 15'd0)
                                            begin
                                                drive       = rps_pkg::DRV_START;
                                                status_next = rps_pkg::ST_ON;
                                                timer_load  = {1'b0, on_period_reg};
                                            end
                                        end
                                        else if (status_reg == rps_pkg::ST_ON)
                                        begin
                                            if (off_period_reg != 15'd0)
                                            begin
                                                drive       = rps_pkg::DRV_STOP;
                                                status_next = rps_pkg::ST_OFF;
                                                timer_load  = {1'b0, off_period_reg};
                                            end
                                        end
                                    end
                                    // The timer holds at minus one rather than wrapping.
                                    if (timer_load != 16'hFFFF)
                                    begin
                                        timer_next = timer_load - 16'd1;
                                    end
                                    else
                                    begin
                                        timer_next = timer_load;
                                    end
                                    // A run of zero never ends.
                                    if (remaining_reg != 16'd0)
                                    begin
                                        if (rem_dec == 16'd0)
                                        begin
                                            activity_next  = rps_pkg::ACT_STOPPING;
                                            remaining_next = rps_pkg::WIND_DOWN;
                                        end
                                        else
                                        begin
                                            remaining_next = rem_dec;
                                        end
                                    end
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                        else if (status_reg != rps_pkg::ST_ABSENT && remaining_reg != 16'd0)
                        begin
                            // Shutdown behaviour: count the run down and keep the
                            // motor stopped.
                            remaining_next = rem_dec;
                            drive          = rps_pkg::DRV_STOP;
                        end
                    end
                    rps_pkg::CMD_RESET:
                    begin
                        if (selected)
                        begin
                            if (pak_reg)
                            begin
                                status_next = rps_pkg::ST_OFF;
                                drive       = rps_pkg::DRV_STOP;
                            end
                            else
                            begin
                                status_next = rps_pkg::ST_ABSENT;
                            end
                            activity_next = rps_pkg::ACT_IDLE;
                        end
                    end
                    rps_pkg::CMD_START:
                    begin
                        if (selected && status_reg != rps_pkg::ST_ABSENT)
                        begin
                            activity_next = rps_pkg::ACT_STARTING;
                        end
                    end
                    rps_pkg::CMD_STOP:
                    begin
                        if (selected && status_reg != rps_pkg::ST_ABSENT)
                        begin
                            activity_next  = rps_pkg::ACT_STOPPING;
                            remaining_next = rps_pkg::WIND_DOWN;
                        end
                    end
                    rps_pkg::CMD_REPEAT:
                    begin
                        if (selected && status_reg != rps_pkg::ST_ABSENT)
                        begin
                            status_next     = rps_pkg::ST_OFF;
                            activity_next   = rps_pkg::ACT_OSC;
                            on_period_next  = on_reg;
                            off_period_next = off_reg;
                            remaining_next  = {1'b0, run_reg};
                            timer_next      = 16'd0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            assign chan_drive[c] = drive;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    status_reg     <= rps_pkg::ST_ABSENT;
                    activity_reg   <= rps_pkg::ACT_IDLE;
                    timer_reg      <= '0;
                    remaining_reg  <= '0;
                    on_period_reg  <= '0;
                    off_period_reg <= '0;
                end
                else if (advance)
                begin
                    status_reg     <= status_next;
                    activity_reg   <= activity_next;
                    timer_reg      <= timer_next;
                    remaining_reg  <= remaining_next;
                    on_period_reg  <= on_period_next;
                    off_period_reg <= off_period_next;
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // Result register. Drive fields with no channel behind them stay at
    // no action.
    // ------------------------------------------------------------------
    rps_pkg::drive_t drive_next [rps_pkg::NUM_DRIVES];
    rps_pkg::drive_t drive_reg  [rps_pkg::NUM_DRIVES];

    genvar k;
    generate
        for (k = 0; k < rps_pkg::NUM_DRIVES; k++)
        begin : g_drive
            if (k < CHANNELS)
            begin : g_used
                assign drive_next[k] = chan_drive[k];
            end
            else
            begin : g_unused
                assign drive_next[k] = rps_pkg::DRV_NONE;
            end

            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    drive_reg[k] <= drive_next[k];
                end
            end
        end
    endgenerate

    assign out_valid_next = advance || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign drive_0   = drive_reg[0];
    assign drive_1   = drive_reg[1];
    assign drive_2   = drive_reg[2];
    assign drive_3   = drive_reg[3];

endmodule
